// ===== hw/rtl/zfla_pkg.sv =====
// Shared types and constants of the zoned free-list allocator.
// Request and response structs, opcode and status codes, register layout.
// No dependencies; every other file of the block but zfla_ram refers to this package.
`default_nettype none

package zfla_pkg;

  // Payload field widths
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned ZONE_W   = 2;
  localparam int unsigned STATUS_W = 2;

  // Configuration register file
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_REGS  = 4;
  localparam int unsigned REG_IW    = 2;

  localparam logic [CFG_W-1:0] REG_RST [NUM_REGS] = '{6'd32, 6'd0, 6'd0, 6'd0};

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [ZONE_W-1:0] zone;
    logic [SLOT_W-1:0] slot_in;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot_out;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/zfla_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Width and depth are parameters; no reset on the storage or the read data.
// Standalone, used by the allocator for the shared next-slot links.
`default_nettype none

module zfla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; the read data is registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/zoned_free_list_allocator.sv =====
// Top level of the zoned free-list allocator: per-zone head, tail and count,
// with the links of all zones in one next-slot RAM. Uses zfla_pkg, zfla_ram.
//
// Usage:
//   Requests arrive on req_i and are taken at a clock edge with start high
//   and busy low. Each transaction yields exactly one response on rsp_o,
//   marked by done_o for one cycle, in the cycle after the request was taken.
//   A free or any rejected request leaves busy low, so a new transaction can
//   follow in the next cycle. An allocate that pops a slot holds busy high
//   for one cycle while the link of the popped slot is read from the
//   next-slot RAM and becomes the new head. That RAM read is what sets the
//   allocate rate.
//   The cfg port writes one slot-count register per edge with cfg_we_i high;
//   a write re-initializes that zone's free list to slots 0 to n-1. Write it
//   only while no transaction is in flight.
//   Reset makes zone 0 hold 32 slots and the other zones none. Links that
//   were never written since the last init of their zone read as slot plus
//   one, through one valid flag per RAM entry that reset clears at once, so
//   no clearing pass is needed.
//   Responses are not back-pressured: the receiver must take done_o when it
//   is shown.
`default_nettype none

module zoned_free_list_allocator #(
  parameter int unsigned SLOTS = 32,
  parameter int unsigned ZONES = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire zfla_pkg::req_t                req_i,
  output logic                               done_o,
  output zfla_pkg::rsp_t                     rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [zfla_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [zfla_pkg::CFG_W-1:0]    cfg_wdata_i
);

  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned ZW    = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int unsigned DEPTH = ZONES * SLOTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned MW    = (CW > zfla_pkg::CFG_W) ? CW : zfla_pkg::CFG_W;
  localparam int unsigned KW    = (CW > zfla_pkg::SLOT_W) ? CW : zfla_pkg::SLOT_W;

  typedef enum logic [0:0] {
    S_IDLE,
    S_READ
  } state_e;

  // Clamp a register value to the number of slots a zone can hold
  function automatic logic [CW-1:0] clamp_size(input logic [zfla_pkg::CFG_W-1:0] v);
    logic [MW-1:0] ext;
    ext = MW'(v);
    if (ext > MW'(SLOTS)) begin
      return CW'(SLOTS);
    end
    return CW'(ext);
  endfunction

  function automatic logic [SW-1:0] last_slot(input logic [CW-1:0] n);
    return (n == '0) ? '0 : SW'(n - CW'(1));
  endfunction

  function automatic logic [CW-1:0] reset_size(input int unsigned z);
    return (z < zfla_pkg::NUM_REGS) ? clamp_size(zfla_pkg::REG_RST[z]) : '0;
  endfunction

  function automatic logic [AW-1:0] link_addr(input logic [ZW-1:0] z,
                                               input logic [SW-1:0] s);
    return AW'(z) * AW'(SLOTS) + AW'(s);
  endfunction

  // Registers
  logic [zfla_pkg::CFG_W-1:0] zone_reg_q [zfla_pkg::NUM_REGS];
  logic [SW-1:0]              head_q [ZONES];
  logic [SW-1:0]              tail_q [ZONES];
  logic [CW-1:0]              cnt_q  [ZONES];
  logic [DEPTH-1:0]           vld_q;

  state_e         st_q, st_d;
  logic           done_q, done_d;
  zfla_pkg::rsp_t rsp_q, rsp_d;
  logic [ZW-1:0]  zidx_q;
  logic [SW-1:0]  pop_q;
  logic [AW-1:0]  raddr_q;

  // Zone sizes as currently configured
  logic [CW-1:0] zsize [ZONES];
  always_comb begin
    for (int z = 0; z < ZONES; z++) begin
      zsize[z] = (z < zfla_pkg::NUM_REGS) ? clamp_size(zone_reg_q[z]) : '0;
    end
  end

  // Decode the incoming transaction
  logic          accept;
  logic          zone_ok;
  logic [ZW-1:0] zidx;
  logic [CW-1:0] cur_cnt, cur_n;
  logic [SW-1:0] cur_head, cur_tail, free_slot;
  logic          slot_fits;
  logic          alloc_go, free_go;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [SW-1:0] ram_rdata;

  assign accept    = start && !busy;
  assign zone_ok   = 32'(req_i.zone) < ZONES;
  assign zidx      = ZW'(req_i.zone);
  assign cur_cnt   = zone_ok ? cnt_q[zidx]  : '0;
  assign cur_n     = zone_ok ? zsize[zidx]  : '0;
  assign cur_head  = zone_ok ? head_q[zidx] : '0;
  assign cur_tail  = zone_ok ? tail_q[zidx] : '0;
  assign slot_fits = KW'(req_i.slot_in) < KW'(cur_n);
  assign free_slot = SW'(req_i.slot_in);

  always_comb begin
    st_d     = st_q;
    done_d   = 1'b0;
    rsp_d    = '{status: zfla_pkg::ST_OK, slot_out: '0};
    alloc_go = 1'b0;
    free_go  = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          if (!zone_ok) begin
            rsp_d.status = (req_i.op == zfla_pkg::OP_ALLOC) ?
                           zfla_pkg::ST_EXHAUSTED : zfla_pkg::ST_RANGE;
          end else if (req_i.op == zfla_pkg::OP_ALLOC) begin
            if (cur_cnt == '0) begin
              rsp_d.status = zfla_pkg::ST_EXHAUSTED;
            end else begin
              rsp_d.slot_out = zfla_pkg::SLOT_W'(cur_head);
              alloc_go       = 1'b1;
              st_d           = S_READ;
            end
          end else begin
            if (!slot_fits || cur_cnt >= cur_n) begin
              rsp_d.status = zfla_pkg::ST_RANGE;
            end else begin
              free_go = 1'b1;
            end
          end
        end
      end
      S_READ: begin
        st_d = S_IDLE;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // Link a free onto the tail; fetch the link of a popped head. Both happen
  // only on a taken transaction, so a read and a write never share a cycle.
  assign ram_we    = free_go && (cur_cnt != '0);
  assign ram_waddr = link_addr(zidx, cur_tail);
  assign ram_re    = alloc_go;
  assign ram_raddr = link_addr(zidx, cur_head);

  zfla_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (free_slot),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Link of the popped slot: stored value, or slot plus one if never written
  logic [SW-1:0] next_head;
  always_comb begin
    if (vld_q[raddr_q]) begin
      next_head = ram_rdata;
    end else if (32'(pop_q) == SLOTS - 1) begin
      next_head = '0;
    end else begin
      next_head = pop_q + SW'(1);
    end
  end

  logic          cfg_hit, cfg_zone;
  logic [ZW-1:0] cfg_z;
  logic [CW-1:0] cfg_n;
  assign cfg_hit  = cfg_we_i && (32'(cfg_idx_i) < zfla_pkg::NUM_REGS);
  assign cfg_zone = cfg_hit && (32'(cfg_idx_i) < ZONES);
  assign cfg_z    = ZW'(cfg_idx_i);
  assign cfg_n    = clamp_size(cfg_wdata_i);

  // State machine and registered response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q   <= rsp_d;
      zidx_q  <= zidx;
      pop_q   <= cur_head;
      raddr_q <= ram_raddr;
    end
  end

  // Hold the slot-count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < zfla_pkg::NUM_REGS; r++) begin
        zone_reg_q[r] <= zfla_pkg::REG_RST[r];
      end
    end else if (cfg_hit) begin
      zone_reg_q[cfg_idx_i[zfla_pkg::REG_IW-1:0]] <= cfg_wdata_i;
    end
  end

  // Update head, tail and count of the zones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int z = 0; z < ZONES; z++) begin
        head_q[z] <= '0;
        tail_q[z] <= last_slot(reset_size(z));
        cnt_q[z]  <= reset_size(z);
      end
    end else begin
      if (cfg_zone) begin
        head_q[cfg_z] <= '0;
        tail_q[cfg_z] <= last_slot(cfg_n);
        cnt_q[cfg_z]  <= cfg_n;
      end
      if (alloc_go) begin
        cnt_q[zidx] <= cur_cnt - CW'(1);
      end
      if (free_go) begin
        cnt_q[zidx]  <= cur_cnt + CW'(1);
        tail_q[zidx] <= free_slot;
        if (cur_cnt == '0) begin
          head_q[zidx] <= free_slot;
        end
      end
      if (st_q == S_READ) begin
        head_q[zidx_q] <= next_head;
      end
    end
  end

  // Track which links were written since their zone was last initialized
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (cfg_zone) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (32'(cfg_z) == i / SLOTS) begin
            vld_q[i] <= 1'b0;
          end
        end
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
    end
  end

  assign busy   = (st_q == S_READ);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/zfla_chk.sv =====
// Port-level checker for the zoned free-list allocator, bound to the top.
// Checks response timing against taken transactions and status consistency.
// Depends on zfla_pkg and the port list of zoned_free_list_allocator.
`default_nettype none

module zfla_chk (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire zfla_pkg::req_t req_i,
  input wire logic           done_o,
  input wire zfla_pkg::rsp_t rsp_o
);

  // Every taken transaction answers in the next cycle
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("taken transaction without response in next cycle");

  // No response without a transaction taken the cycle before
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("response without a taken transaction");

  // Busy lasts one cycle, right after a taken transaction that shows an OK response
  a_busy_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> ($past(start && !busy) && done_o && rsp_o.status == zfla_pkg::ST_OK))
    else $error("busy outside a successful allocate");

  // Rejected transactions carry slot zero
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != zfla_pkg::ST_OK) |-> (rsp_o.slot_out == '0))
    else $error("rejected transaction with nonzero slot");

  // Exhausted only answers an allocate
  a_exh_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == zfla_pkg::ST_EXHAUSTED) |->
    ($past(req_i.op) == zfla_pkg::OP_ALLOC))
    else $error("exhausted status on a free");

endmodule

bind zoned_free_list_allocator zfla_chk u_zfla_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire

// ===== tb/zoned_free_list_allocator_tb.sv =====
// Self-checking testbench for the zoned free-list allocator.
// Holds a free-list tracker class that predicts every response, and the top module
// that drives requests and register writes. Depends on zfla_pkg and the block's RTL.

class free_list_tracker;
  localparam int unsigned POOL   = 2 ** zfla_pkg::SLOT_W;
  localparam int unsigned NZONES = 4;

  logic [zfla_pkg::CFG_W-1:0]  zone_slots [NZONES];
  logic [zfla_pkg::SLOT_W-1:0] link       [NZONES][POOL];
  logic [zfla_pkg::SLOT_W-1:0] head       [NZONES];
  logic [zfla_pkg::SLOT_W-1:0] tail       [NZONES];
  logic [zfla_pkg::CFG_W-1:0]  avail      [NZONES];
  logic [POOL-1:0]             lent       [NZONES];
  zfla_pkg::rsp_t              pending_rsp [$];
  int unsigned                 errors;

  function new();
    int unsigned z;
    errors = 0;
    for (z = 0; z < NZONES; z++) begin
      zone_slots[z] = zfla_pkg::REG_RST[z];
      init_zone(z);
    end
  endfunction

  // Clamp the programmed count to the pool size
  function int unsigned size_of(int unsigned z);
    int unsigned n;
    n = 32'(zone_slots[z]);
    return (n > POOL) ? POOL : n;
  endfunction

  // Rebuild the zone's list as slots 0 to n-1 in order
  function void init_zone(int unsigned z);
    int unsigned i;
    int unsigned n;
    n = size_of(z);
    for (i = 0; i < POOL; i++) link[z][i] = zfla_pkg::SLOT_W'((i + 1) % POOL);
    head[z]  = '0;
    tail[z]  = (n == 0) ? '0 : zfla_pkg::SLOT_W'(n - 1);
    avail[z] = zfla_pkg::CFG_W'(n);
    lent[z]  = '0;
  endfunction

  // Apply a register write; indexes past the list do nothing
  function void write_reg(logic [zfla_pkg::CFG_IDX_W-1:0] idx,
                          logic [zfla_pkg::CFG_W-1:0] val);
    if (idx >= zfla_pkg::NUM_REGS) return;
    zone_slots[idx] = val;
    init_zone(32'(idx));
  endfunction

  // Advance the lists for one accepted transaction and queue its response
  function void note_request(zfla_pkg::req_t r);
    zfla_pkg::rsp_t want;
    int unsigned    z;
    int unsigned    n;
    z = 32'(r.zone);
    n = size_of(z);
    want.status   = zfla_pkg::ST_OK;
    want.slot_out = '0;
    if (r.op == zfla_pkg::OP_ALLOC) begin
      if (avail[z] == 0) begin
        want.status = zfla_pkg::ST_EXHAUSTED;
      end else begin
        want.slot_out = head[z];
        head[z] = link[z][head[z]];
        avail[z]--;
        lent[z][want.slot_out] = 1'b1;
      end
    end else if (r.slot_in >= n || avail[z] >= n) begin
      want.status = zfla_pkg::ST_RANGE;
    end else begin
      // Append at the tail; an empty list takes the slot as its head
      if (avail[z] == 0) head[z] = r.slot_in;
      else link[z][tail[z]] = r.slot_in;
      tail[z] = r.slot_in;
      avail[z]++;
      lent[z][r.slot_in] = 1'b0;
    end
    pending_rsp.push_back(want);
  endfunction

  // Compare one response with the oldest prediction
  function void check_response(zfla_pkg::rsp_t got);
    zfla_pkg::rsp_t want;
    if (pending_rsp.size() == 0) begin
      $error("response with no transaction outstanding: status %0d slot_out %0d",
             got.status, got.slot_out);
      errors++;
      return;
    end
    want = pending_rsp.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.slot_out !== want.slot_out) begin
      $error("slot_out: expected %0d, actual %0d", want.slot_out, got.slot_out);
      errors++;
    end
  endfunction

  function void finish_check();
    if (pending_rsp.size() != 0) begin
      $error("%0d responses never arrived", pending_rsp.size());
      errors++;
    end
  endfunction

  // Find a slot currently handed out in the zone, starting at a random point
  function bit pick_lent(int unsigned z, output logic [zfla_pkg::SLOT_W-1:0] s);
    int unsigned k;
    int unsigned base;
    base = $urandom_range(POOL - 1);
    for (k = 0; k < POOL; k++) begin
      if (lent[z][(base + k) % POOL]) begin
        s = zfla_pkg::SLOT_W'((base + k) % POOL);
        return 1'b1;
      end
    end
    s = '0;
    return 1'b0;
  endfunction
endclass

module zoned_free_list_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zfla_pkg::*;

  localparam int unsigned STALL_LIMIT = 400;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam int unsigned BURST       = 16;
  localparam int unsigned REQ_W       = $bits(req_t);

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  req_t                 req_i       = '0;
  logic                 done_o;
  rsp_t                 rsp_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  free_list_tracker sb;
  int unsigned      stall_cycles = 0;

  zoned_free_list_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Sample every handshake at the rising edge; check responses before noting new requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_response(rsp_o);
      if (start && !busy) sb.note_request(req_i);
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (done_o || (start && !busy) || cfg_we_i) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Hold the request for one transaction after an optional idle gap
  task automatic issue_request(req_t r, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      req_i <= req_t'(REQ_W'($urandom));
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Drop start and wait until every predicted response has come back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(int unsigned idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_IDX_W'(idx);
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic req_t mk_req(op_e op, int unsigned zone, int unsigned slot);
    req_t r;
    r.op      = op;
    r.zone    = ZONE_W'(zone);
    r.slot_in = SLOT_W'(slot);
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(6))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'd63;
      4: return CFG_W'($urandom_range(63, 33));
      default: return CFG_W'($urandom_range(31, 2));
    endcase
  endfunction

  // Favor zones that hold slots so the lists see real traffic
  function automatic int unsigned pick_zone();
    int unsigned k;
    int unsigned z;
    z = $urandom_range(3);
    if ($urandom_range(99) < 85) begin
      for (k = 0; k < 8; k++) begin
        if (sb.size_of(z) != 0) break;
        z = $urandom_range(3);
      end
    end
    return z;
  endfunction

  // Mostly allocs and frees of lent slots; some frees of arbitrary slots
  function automatic req_t random_request(int unsigned alloc_pct);
    req_t              r;
    int unsigned       z;
    logic [SLOT_W-1:0] s;
    z = pick_zone();
    if ($urandom_range(99) < alloc_pct) begin
      r = mk_req(OP_ALLOC, z, $urandom_range(31));
    end else if ($urandom_range(9) < 8 && sb.pick_lent(z, s)) begin
      r = mk_req(OP_FREE, z, 32'(s));
    end else begin
      r = mk_req(OP_FREE, z, $urandom_range(31));
    end
    return r;
  endfunction

  initial begin
    logic [CFG_W-1:0] counts [4];
    int unsigned      ph;
    int unsigned      i;
    int unsigned      z;
    int unsigned      alloc_pct;
    bit               quiet;

    sb = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset layout: zone 0 full, the rest empty
    issue_request(mk_req(OP_ALLOC, 0, 0), 0);
    issue_request(mk_req(OP_ALLOC, 0, 31), 0);
    issue_request(mk_req(OP_FREE, 0, 1), 1);
    issue_request(mk_req(OP_FREE, 0, 0), 0);
    issue_request(mk_req(OP_FREE, 0, 31), 0);
    issue_request(mk_req(OP_ALLOC, 1, 0), 2);
    issue_request(mk_req(OP_FREE, 1, 0), 0);
    issue_request(mk_req(OP_FREE, 3, 31), 0);
    drain();

    // Minimum, clamped and unlisted register writes
    write_reg(1, 6'd1);
    write_reg(2, 6'd63);
    write_reg(3, 6'd33);
    write_reg(4, 6'd0);
    write_reg(7, 6'd63);
    write_reg(0, 6'd32);

    // One-slot zone: pop, exhaust, out-of-range, refill, free into a full zone
    issue_request(mk_req(OP_ALLOC, 1, 0), 0);
    issue_request(mk_req(OP_ALLOC, 1, 0), 0);
    issue_request(mk_req(OP_FREE, 1, 31), 0);
    issue_request(mk_req(OP_FREE, 1, 0), 0);
    issue_request(mk_req(OP_FREE, 1, 0), 0);
    // Double free goes undetected while the zone is not full
    issue_request(mk_req(OP_ALLOC, 2, 0), 0);
    issue_request(mk_req(OP_ALLOC, 2, 0), 1);
    issue_request(mk_req(OP_FREE, 2, 31), 0);
    issue_request(mk_req(OP_FREE, 2, 31), 0);
    issue_request(mk_req(OP_ALLOC, 3, 17), 0);
    issue_request(mk_req(OP_FREE, 3, 31), 0);
    issue_request(mk_req(OP_ALLOC, 0, 31), 0);
    drain();

    // Empty zone rejects both operations
    write_reg(0, 6'd0);
    issue_request(mk_req(OP_ALLOC, 0, 0), 0);
    issue_request(mk_req(OP_FREE, 0, 0), 0);
    drain();

    // Random traffic across several register settings
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: counts = '{6'd2, 6'd32, 6'd1, 6'd0};
        1: counts = '{6'd63, 6'd33, 6'd32, 6'd5};
        default: for (z = 0; z < 4; z++) counts[z] = pick_count();
      endcase
      for (z = 0; z < 4; z++) write_reg(z, counts[z]);
      if ($urandom_range(1)) write_reg($urandom_range(7, 4), pick_count());

      alloc_pct = 50;
      quiet = 1'b0;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i % BURST == 0) begin
          case ($urandom_range(2))
            0: alloc_pct = 20;
            1: alloc_pct = 50;
            default: alloc_pct = 80;
          endcase
          quiet = ($urandom_range(2) == 0);
        end
        // Hold off the sender mid-phase until the pipeline is empty
        if (i == PHASE_ITEMS / 2) drain();
        issue_request(random_request(alloc_pct), quiet ? 0 : $urandom_range(17));
      end
      drain();
    end

    sb.finish_check();
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
